FILE: design/ive_pkg.sv
// ----------------------------------------------------------------------------
// ive_pkg: shared types and constants of the increment volatility estimator
// Word formats of both channels, datapath widths and the request and response
// of the shared compare-subtract unit.
// ----------------------------------------------------------------------------
package ive_pkg;

    // Sample width used out of the 16-bit input field and the sample bound
    localparam int SAMPLE_BITS = 16;
    localparam int MAX_SAMPLES = 65536;

    // Datapath widths
    localparam int DIFF_BITS  = SAMPLE_BITS + 1;
    localparam int SQ_BITS    = 2 * DIFF_BITS;
    localparam int SUM_BITS   = 48;
    localparam int FRAC_SHIFT = 16;
    localparam int NUM_BITS   = SUM_BITS + FRAC_SHIFT;
    localparam int ROOT_BITS  = NUM_BITS / 2;
    localparam int ALU_BITS   = ROOT_BITS + 2;
    localparam int COUNT_BITS = $clog2(MAX_SAMPLES + 1);
    localparam int STEP_BITS  = $clog2(NUM_BITS);
    localparam int VOL_BITS   = 24;

    // Input word
    typedef struct packed {
        logic signed [15:0] sample;
        logic               last;
    } in_word_t;

    // Output word
    typedef struct packed {
        logic [VOL_BITS-1:0]   vol_estimate;
        logic [16:0]           sample_count;
        logic                  overflow;
    } out_word_t;

    // Shared compare-subtract unit
    typedef struct packed {
        logic [ALU_BITS-1:0] minuend;
        logic [ALU_BITS-1:0] subtrahend;
    } sub_req_t;

    typedef struct packed {
        logic [ALU_BITS-1:0] difference;
        logic                no_borrow;
    } sub_rsp_t;

endpackage

FILE: design/ive_sub_unit.sv
// ----------------------------------------------------------------------------
// ive_sub_unit: shared compare-subtract unit
// Subtracts and reports whether the minuend was at least the subtrahend.
// Serves both the restoring divider and the digit-by-digit square root.
// ----------------------------------------------------------------------------
module ive_sub_unit
    import ive_pkg::*;
(
    input  sub_req_t req,
    output sub_rsp_t rsp
);

    logic [ALU_BITS:0] wide_diff;

    // Subtract with one extra bit to catch the borrow
    assign wide_diff = {1'b0, req.minuend} - {1'b0, req.subtrahend};

    assign rsp.difference = wide_diff[ALU_BITS-1:0];
    assign rsp.no_borrow  = ~wide_diff[ALU_BITS];

endmodule

FILE: design/increment_volatility_estimator.sv
// ----------------------------------------------------------------------------
// increment_volatility_estimator: volatility of a sampled path
// Sums squared successive differences and, on the last sample, returns
// floor(sqrt(floor(sum * 65536 / count))) with 8 fraction bits.
// ----------------------------------------------------------------------------
// Sequence: the first sample of a sequence is only accepted, every later
// sample is accepted, squared and accumulated. The last sample then adds a
// restoring divide and a square root, both on the one shared compare-subtract
// unit, with a setup state before each and a hand-off state before the result
// word is loaded. in_ready is
// low while a word is in work. The result sits in an output register, so the
// next sequence may start while it waits; only loading the next result waits
// on out_ready. A sample that arrives with the count at the bound is dropped
// and sets the overflow flag.
// ----------------------------------------------------------------------------
module increment_volatility_estimator
    import ive_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_ready,
    input  in_word_t  in_data,
    output logic      out_valid,
    input  logic      out_ready,
    output out_word_t out_data
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SQUARE,
        ST_ACCUM,
        ST_DIV_INIT,
        ST_DIV,
        ST_SQRT_INIT,
        ST_SQRT,
        ST_DONE
    } state_t;

    state_t                       state_reg, state_next;
    logic signed [SAMPLE_BITS-1:0] prev_reg, prev_next;
    logic                         have_prev_reg, have_prev_next;
    logic [SUM_BITS-1:0]          sum_reg, sum_next;
    logic [COUNT_BITS-1:0]        count_reg, count_next;
    logic                         ovf_reg, ovf_next;
    logic                         last_reg, last_next;
    logic signed [DIFF_BITS-1:0]  diff_reg, diff_next;
    logic [SQ_BITS-1:0]           sq_reg, sq_next;
    logic [NUM_BITS-1:0]          work_reg, work_next;
    logic [ALU_BITS-1:0]          rem_reg, rem_next;
    logic [ROOT_BITS-1:0]         root_reg, root_next;
    logic [STEP_BITS-1:0]         step_reg, step_next;
    logic                         out_valid_reg, out_valid_next;
    out_word_t                    out_data_reg, out_data_next;

    sub_req_t                     sub_req;
    sub_rsp_t                     sub_rsp;

    logic signed [SAMPLE_BITS-1:0] in_sample;
    logic [DIFF_BITS-1:0]         diff_mag;
    logic [SUM_BITS:0]            sum_wide;
    logic [COUNT_BITS-1:0]        divisor;
    logic [VOL_BITS-1:0]          vol_sat;

    ive_sub_unit u_sub (
        .req (sub_req),
        .rsp (sub_rsp)
    );

    // Use the low sample bits, sign-extended
    assign in_sample = signed'(in_data.sample[SAMPLE_BITS-1:0]);

    // Magnitude of the stored difference
    assign diff_mag = diff_reg[DIFF_BITS-1] ? DIFF_BITS'(-diff_reg) : DIFF_BITS'(diff_reg);

    // Saturating accumulate
    assign sum_wide = {1'b0, sum_reg} + (SUM_BITS + 1)'(sq_reg);

    // Guard against an empty count
    assign divisor = (count_reg == '0) ? COUNT_BITS'(1) : count_reg;

    // Clamp the root to the output width
    assign vol_sat = (|root_reg[ROOT_BITS-1:VOL_BITS]) ? '1 : root_reg[VOL_BITS-1:0];

    assign in_ready  = (state_reg == ST_IDLE);
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    // Sequencer and datapath next values
    always_comb
    begin
        state_next     = state_reg;
        prev_next      = prev_reg;
        have_prev_next = have_prev_reg;
        sum_next       = sum_reg;
        count_next     = count_reg;
        ovf_next       = ovf_reg;
        last_next      = last_reg;
        diff_next      = diff_reg;
        sq_next        = sq_reg;
        work_next      = work_reg;
        rem_next       = rem_reg;
        root_next      = root_reg;
        step_next      = step_reg;
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        sub_req        = '0;

        // Drop the result word once taken
        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    last_next = in_data.last;
                    if (count_reg >= COUNT_BITS'(MAX_SAMPLES))
                    begin
                        ovf_next   = 1'b1;
                        state_next = in_data.last ? ST_DIV_INIT : ST_IDLE;
                    end
                    else
                    begin
                        if (have_prev_reg)
                        begin
                            diff_next  = DIFF_BITS'(in_sample) - DIFF_BITS'(prev_reg);
                            state_next = ST_SQUARE;
                        end
                        else
                        begin
                            state_next = in_data.last ? ST_DIV_INIT : ST_IDLE;
                        end
                        prev_next      = in_sample;
                        have_prev_next = 1'b1;
                        count_next     = count_reg + COUNT_BITS'(1);
                    end
                end
            end

            ST_SQUARE:
            begin
                sq_next    = SQ_BITS'(diff_mag) * SQ_BITS'(diff_mag);
                state_next = ST_ACCUM;
            end

            ST_ACCUM:
            begin
                sum_next   = sum_wide[SUM_BITS] ? '1 : sum_wide[SUM_BITS-1:0];
                state_next = last_reg ? ST_DIV_INIT : ST_IDLE;
            end

            ST_DIV_INIT:
            begin
                work_next  = {sum_reg, FRAC_SHIFT'(0)};
                rem_next   = '0;
                step_next  = '0;
                state_next = ST_DIV;
            end

            // Restoring divide, one quotient bit per cycle
            ST_DIV:
            begin
                sub_req.minuend    = ALU_BITS'({rem_reg[COUNT_BITS-1:0],
                                                work_reg[NUM_BITS-1]});
                sub_req.subtrahend = ALU_BITS'(divisor);
                rem_next  = sub_rsp.no_borrow ? sub_rsp.difference : sub_req.minuend;
                work_next = {work_reg[NUM_BITS-2:0], sub_rsp.no_borrow};
                step_next = step_reg + STEP_BITS'(1);
                if (step_reg == STEP_BITS'(NUM_BITS - 1))
                begin
                    state_next = ST_SQRT_INIT;
                end
            end

            ST_SQRT_INIT:
            begin
                rem_next   = '0;
                root_next  = '0;
                step_next  = '0;
                state_next = ST_SQRT;
            end

            // Digit-by-digit square root, one root bit per cycle
            ST_SQRT:
            begin
                sub_req.minuend    = {rem_reg[ROOT_BITS-1:0], work_reg[NUM_BITS-1 -: 2]};
                sub_req.subtrahend = {root_reg, 2'b01};
                rem_next  = sub_rsp.no_borrow ? sub_rsp.difference : sub_req.minuend;
                root_next = {root_reg[ROOT_BITS-2:0], sub_rsp.no_borrow};
                work_next = {work_reg[NUM_BITS-3:0], 2'b00};
                step_next = step_reg + STEP_BITS'(1);
                if (step_reg == STEP_BITS'(ROOT_BITS - 1))
                begin
                    state_next = ST_DONE;
                end
            end

            // Load the result word once the output register is free and clear the sequence state
            ST_DONE:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_data_next.vol_estimate = vol_sat;
                    out_data_next.sample_count = 17'(count_reg);
                    out_data_next.overflow     = ovf_reg;
                    out_valid_next = 1'b1;
                    prev_next      = '0;
                    have_prev_next = 1'b0;
                    sum_next       = '0;
                    count_next     = '0;
                    ovf_next       = 1'b0;
                    state_next     = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Hold state, datapath and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            prev_reg      <= '0;
            have_prev_reg <= 1'b0;
            sum_reg       <= '0;
            count_reg     <= '0;
            ovf_reg       <= 1'b0;
            last_reg      <= 1'b0;
            step_reg      <= '0;
            out_valid_reg <= 1'b0;
            diff_reg      <= '0;
            sq_reg        <= '0;
            work_reg      <= '0;
            rem_reg       <= '0;
            root_reg      <= '0;
            out_data_reg  <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            prev_reg      <= prev_next;
            have_prev_reg <= have_prev_next;
            sum_reg       <= sum_next;
            count_reg     <= count_next;
            ovf_reg       <= ovf_next;
            last_reg      <= last_next;
            step_reg      <= step_next;
            out_valid_reg <= out_valid_next;
            diff_reg      <= diff_next;
            sq_reg        <= sq_next;
            work_reg      <= work_next;
            rem_reg       <= rem_next;
            root_reg      <= root_next;
            out_data_reg  <= out_data_next;
        end
    end

endmodule
